// ----- src/rau_pkg.sv -----
// Package for the rational arithmetic unit: word sizes, operation and status codes,
// sequencer states and the operand split function. Depends on nothing.
`default_nettype none

package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS);
    localparam int FIELD_BITS = 32;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADDEN   = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GCD,
        S_DIV,
        S_DONE
    } state_t;

    // Magnitude of the low WORD_BITS bits read as two's complement. The most
    // negative value maps onto itself, which is its correct unsigned magnitude.
    function automatic logic [WORD_BITS-1:0] mag_of(input logic [FIELD_BITS-1:0] raw);
        logic [WORD_BITS-1:0] v;
        v = raw[WORD_BITS-1:0];
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

`default_nettype wire

// ----- src/rau_if.sv -----
// Handshake interfaces for the rational arithmetic unit: request and response items.
// Depends on rau_pkg for the field widths.
`default_nettype none

interface rau_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic signed [rau_pkg::FIELD_BITS-1:0] num_a;
    logic signed [rau_pkg::FIELD_BITS-1:0] den_a;
    logic signed [rau_pkg::FIELD_BITS-1:0] num_b;
    logic signed [rau_pkg::FIELD_BITS-1:0] den_b;

    modport source (output valid, kind, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, kind, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [rau_pkg::FIELD_BITS-1:0] res_num;
    logic [rau_pkg::FIELD_BITS-2:0]    res_den;
    logic [1:0]                        status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

`default_nettype wire

// ----- src/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions and
// reduces the result. Depends on rau_pkg and the interfaces in rau_if.sv.
//
//   channel  direction  carries
//   req      in         kind, num_a, den_a, num_b, den_b
//   rsp      out        res_num, res_den, status
//
// An item whose operand denominator is zero, or that divides by a zero fraction,
// goes straight to hand-over. Otherwise the multiplier forms the cross products, a
// combine step follows, and a zero sum goes straight to hand-over; else a binary GCD
// whose length is set by the operand bits follows, then the divider (first for the
// numerator, then for the denominator), then the hand-over. Reset clears the sequencer
// only. The block takes no request while an item is in work or while its result waits
// on rsp; a stalled rsp simply holds the result.
`default_nettype none

module rational_arithmetic_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rau_req_if.sink     req,
    rau_rsp_if.source   rsp
);

    localparam int W  = rau_pkg::WORD_BITS;
    localparam int P  = rau_pkg::PROD_BITS;
    localparam int CB = rau_pkg::CNT_BITS;

    // Largest positive magnitude at WORD_BITS, in product width.
    localparam logic [P-1:0] LIM = {{(P-W+1){1'b0}}, {(W-1){1'b1}}};

    rau_pkg::state_t state_reg, state_next;

    logic [W-1:0]  na_reg, da_reg, nb_reg, db_reg;
    logic          sa_reg, sb_reg, neg_reg;
    logic          sa_next, sb_next, neg_next;
    logic [W-1:0]  na_next, da_next, nb_next, db_next;
    rau_pkg::kind_t kind_reg, kind_next;
    logic [1:0]    step_reg, step_next;
    logic [P-1:0]  t1_reg, t2_reg, den_reg;
    logic [P-1:0]  t1_next, t2_next, den_next;
    logic [P-1:0]  x_reg, y_reg, x_next, y_next;
    logic [CB-1:0] k_reg, k_next;
    logic [P-1:0]  q_reg, rem_reg, d_reg, qnum_reg;
    logic [P-1:0]  q_next, rem_next, d_next, qnum_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          phase_reg, phase_next;
    logic signed [rau_pkg::FIELD_BITS-1:0] res_num_reg, res_num_next;
    logic [rau_pkg::FIELD_BITS-2:0]        res_den_reg, res_den_next;
    rau_pkg::status_t status_reg, status_next;

    // Operand split of the incoming item.
    logic [W-1:0] in_na, in_da, in_nb, in_db;
    logic         in_sna, in_sda, in_snb, in_sdb;
    logic         accept;

    // Shared multiplier, combine stage, GCD step and divider step.
    logic [W-1:0] mul_a, mul_b;
    logic [P-1:0] mul_p;
    logic         s2;
    logic [P-1:0] comb_num;
    logic         comb_neg;
    logic [P:0]   div_t;
    logic         div_ge;
    logic [P-1:0] div_q;
    logic [P-1:0] div_r;
    logic         div_last;
    logic         gcd_done;
    logic         ovf;

    assign in_na  = rau_pkg::mag_of(req.num_a);
    assign in_da  = rau_pkg::mag_of(req.den_a);
    assign in_nb  = rau_pkg::mag_of(req.num_b);
    assign in_db  = rau_pkg::mag_of(req.den_b);
    assign in_sna = req.num_a[W-1];
    assign in_sda = req.den_a[W-1];
    assign in_snb = req.num_b[W-1];
    assign in_sdb = req.den_b[W-1];
    assign accept = req.valid && req.ready;

    // Step 0 gives the numerator product, step 1 the denominator product and step 2,
    // for add and subtract only, the second cross product.
    always_comb
    begin
        mul_a = na_reg;
        mul_b = db_reg;
        case (step_reg)
            2'd0:
            begin
                mul_a = na_reg;
                mul_b = (kind_reg == rau_pkg::KIND_MUL) ? nb_reg : db_reg;
            end
            2'd1:
            begin
                mul_a = da_reg;
                mul_b = (kind_reg == rau_pkg::KIND_DIV) ? nb_reg : db_reg;
            end
            default:
            begin
                mul_a = nb_reg;
                mul_b = da_reg;
            end
        endcase
    end

    assign mul_p = P'(mul_a) * P'(mul_b);

    // Signed combination of the cross products as sign and magnitude.
    always_comb
    begin
        s2 = (kind_reg == rau_pkg::KIND_SUB) ? !sb_reg : sb_reg;
        comb_num = t1_reg;
        comb_neg = sa_reg ^ sb_reg;
        if (kind_reg == rau_pkg::KIND_ADD || kind_reg == rau_pkg::KIND_SUB)
        begin
            if (sa_reg == s2)
            begin
                comb_num = t1_reg + t2_reg;
                comb_neg = sa_reg;
            end
            else if (t1_reg >= t2_reg)
            begin
                comb_num = t1_reg - t2_reg;
                comb_neg = sa_reg;
            end
            else
            begin
                comb_num = t2_reg - t1_reg;
                comb_neg = s2;
            end
        end
    end

    assign gcd_done = (x_reg == y_reg) && x_reg[0] && y_reg[0];

    // One restoring division step: shift a dividend bit into the remainder.
    assign div_t    = {rem_reg, q_reg[P-1]};
    assign div_ge   = div_t >= {1'b0, d_reg};
    assign div_r    = div_ge ? P'(div_t - {1'b0, d_reg}) : div_t[P-1:0];
    assign div_q    = {q_reg[P-2:0], div_ge};
    assign div_last = (cnt_reg == CB'(P - 1));

    assign ovf = (div_q > LIM) || (qnum_reg > (neg_reg ? LIM + 1'b1 : LIM));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE:
                if (accept)
                begin
                    if (in_da == '0 || in_db == '0 ||
                        (req.kind == rau_pkg::KIND_DIV && in_nb == '0))
                        state_next = rau_pkg::S_DONE;
                    else
                        state_next = rau_pkg::S_MUL;
                end
            rau_pkg::S_MUL:
                if (step_reg == 2'd2 ||
                    (step_reg == 2'd1 && (kind_reg == rau_pkg::KIND_MUL ||
                                          kind_reg == rau_pkg::KIND_DIV)))
                    state_next = rau_pkg::S_COMB;
            rau_pkg::S_COMB:
                state_next = (comb_num == '0) ? rau_pkg::S_DONE : rau_pkg::S_GCD;
            rau_pkg::S_GCD:
                if (gcd_done)
                    state_next = rau_pkg::S_DIV;
            rau_pkg::S_DIV:
                if (div_last && phase_reg)
                    state_next = rau_pkg::S_DONE;
            rau_pkg::S_DONE:
                if (rsp.ready)
                    state_next = rau_pkg::S_IDLE;
            default:
                state_next = rau_pkg::S_IDLE;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        na_next = na_reg;  da_next = da_reg;  nb_next = nb_reg;  db_next = db_reg;
        sa_next = sa_reg;  sb_next = sb_reg;  neg_next = neg_reg;
        kind_next = kind_reg;  step_next = step_reg;
        t1_next = t1_reg;  t2_next = t2_reg;  den_next = den_reg;
        x_next = x_reg;  y_next = y_reg;  k_next = k_reg;
        q_next = q_reg;  rem_next = rem_reg;  d_next = d_reg;  qnum_next = qnum_reg;
        cnt_next = cnt_reg;  phase_next = phase_reg;
        res_num_next = res_num_reg;  res_den_next = res_den_reg;
        status_next = status_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE:
                if (accept)
                begin
                    na_next   = in_na;
                    da_next   = in_da;
                    nb_next   = in_nb;
                    db_next   = in_db;
                    sa_next   = in_sna ^ in_sda;
                    sb_next   = in_snb ^ in_sdb;
                    kind_next = rau_pkg::kind_t'(req.kind);
                    step_next = 2'd0;
                    res_num_next = '0;
                    res_den_next = '0;
                    if (in_da == '0 || in_db == '0)
                        status_next = rau_pkg::ST_BADDEN;
                    else if (req.kind == rau_pkg::KIND_DIV && in_nb == '0)
                        status_next = rau_pkg::ST_DIVZERO;
                    else
                        status_next = rau_pkg::ST_OK;
                end
            rau_pkg::S_MUL:
            begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0:    t1_next  = mul_p;
                    2'd1:    den_next = mul_p;
                    default: t2_next  = mul_p;
                endcase
            end
            rau_pkg::S_COMB:
            begin
                t1_next  = comb_num;
                neg_next = comb_neg;
                x_next   = comb_num;
                y_next   = den_reg;
                k_next   = '0;
                if (comb_num == '0)
                begin
                    res_num_next = '0;
                    res_den_next = 31'd1;
                    status_next  = rau_pkg::ST_OK;
                end
            end
            rau_pkg::S_GCD:
            begin
                // Binary GCD: strip common twos, halve a lone even value, then subtract odd values.
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                    x_next = x_reg >> 1;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (x_reg > y_reg)
                    x_next = x_reg - y_reg;
                else if (y_reg > x_reg)
                    y_next = y_reg - x_reg;
                else
                begin
                    d_next     = x_reg << k_reg;
                    q_next     = t1_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                end
            end
            rau_pkg::S_DIV:
            begin
                q_next   = div_q;
                rem_next = div_r;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    if (!phase_reg)
                    begin
                        qnum_next  = div_q;
                        q_next     = den_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        phase_next = 1'b1;
                    end
                    else if (ovf)
                    begin
                        res_num_next = '0;
                        res_den_next = '0;
                        status_next  = rau_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        res_num_next = neg_reg ? (32'd0 - qnum_reg[31:0]) : qnum_reg[31:0];
                        res_den_next = div_q[30:0];
                        status_next  = rau_pkg::ST_OK;
                    end
                end
            end
            rau_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rau_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        na_reg <= na_next;  da_reg <= da_next;  nb_reg <= nb_next;  db_reg <= db_next;
        sa_reg <= sa_next;  sb_reg <= sb_next;  neg_reg <= neg_next;
        kind_reg <= kind_next;  step_reg <= step_next;
        t1_reg <= t1_next;  t2_reg <= t2_next;  den_reg <= den_next;
        x_reg <= x_next;  y_reg <= y_next;  k_reg <= k_next;
        q_reg <= q_next;  rem_reg <= rem_next;  d_reg <= d_next;  qnum_reg <= qnum_next;
        cnt_reg <= cnt_next;  phase_reg <= phase_next;
        res_num_reg <= res_num_next;  res_den_reg <= res_den_next;
        status_reg <= status_next;
    end

    // Handshake outputs.
    always_comb
    begin
        req.ready   = (state_reg == rau_pkg::S_IDLE);
        rsp.valid   = (state_reg == rau_pkg::S_DONE);
        rsp.res_num = res_num_reg;
        rsp.res_den = res_den_reg;
        rsp.status  = status_reg;
    end

endmodule

`default_nettype wire

// ----- src/rau_checker.sv -----
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and on the ports of rational_arithmetic_unit.
`default_nettype none

module rau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [30:0] rsp_res_den,
    input wire logic [31:0] rsp_res_num,
    input wire logic [1:0]  rsp_status
);

    // The unit never takes a request while a result is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a result waits");

    // A result stays on offer until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_num))
        else $error("result dropped or changed while stalled");

    // Errors give 0/0, successes a positive denominator.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != rau_pkg::ST_OK |-> rsp_res_den == '0 && rsp_res_num == '0)
        else $error("error result not 0/0");

    a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == rau_pkg::ST_OK |-> rsp_res_den != '0)
        else $error("successful result with zero denominator");

    // Once a request is taken, the unit stops accepting until its result has gone.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_res_den (rsp.res_den),
    .rsp_res_num (rsp.res_num),
    .rsp_status  (rsp.status)
);

`default_nettype wire
